/* rtl/core/battery_efficiency_degradation_index_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the efficiency degradation index block
// Implication checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BATTERY_EFFICIENCY_DEGRADATION_INDEX_ASSERT_SVH
`define BATTERY_EFFICIENCY_DEGRADATION_INDEX_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BEDI_ASSERT_IMPLY(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("bedi assertion failed");
`define BEDI_ASSERT_NEXT(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("bedi assertion failed");
`else
`define BEDI_ASSERT_IMPLY(name, clk, rst, cond, prop)
`define BEDI_ASSERT_NEXT(name, clk, rst, cond, prop)
`endif
`endif

/* rtl/core/bedi_pkg.sv */
// ----------------------------------------------------------------------------
// bedi_pkg
// Constants and types shared by the efficiency degradation index block.
// ----------------------------------------------------------------------------
`default_nettype none
package bedi_pkg;

   localparam int DIV_BITS_PER_STAGE = 2;

   localparam logic [2:0] CSR_ETA_START    = 3'd0;
   localparam logic [2:0] CSR_ETA_END      = 3'd1;
   localparam logic [2:0] CSR_TOTAL_CYCLES = 3'd2;
   localparam logic [2:0] CSR_DECAY_BETA   = 3'd3;
   localparam logic [2:0] CSR_TARGET_RATIO = 3'd4;
   localparam logic [2:0] CSR_SAFE_BOUND   = 3'd5;
   localparam logic [2:0] CSR_GOLD_BOUND   = 3'd6;
   localparam logic [2:0] CSR_HARD_BOUND   = 3'd7;

   localparam logic [1:0] BAND_ZERO = 2'd0;
   localparam logic [1:0] BAND_ONE  = 2'd1;
   localparam logic [1:0] BAND_LERP = 2'd2;

   localparam logic [31:0] LN2_Q32     = 32'd2977044472;
   localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
   localparam logic [35:0] EXP_X_LIMIT = 36'd1453635;
   localparam logic [16:0] Q16_ONE     = 17'd65536;
   localparam logic [16:0] Q16_HALF    = 17'd32768;
   localparam logic [15:0] IDX_MAX     = 16'hFFFF;

   typedef struct packed {
      logic        big;
      logic        zero;
      logic [4:0]  shift;
      logic [31:0] r;
   } exp_side_type;

endpackage
`default_nettype wire

/* rtl/core/bedi_div.sv */
// ----------------------------------------------------------------------------
// bedi_div
// Pipelined restoring divider, two quotient bits per stage, with a side
// band that travels along with each word.
// ----------------------------------------------------------------------------
`default_nettype none
module bedi_div #(
   parameter int DW = 36,
   parameter int VW = 16,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire logic          in_valid,
   input  wire logic [DW-1:0] in_dividend,
   input  wire logic [VW-1:0] in_divisor,
   input  wire logic [SW-1:0] in_side,
   output logic               out_valid,
   output logic [DW-1:0]      out_quotient,
   output logic [SW-1:0]      out_side
);
   import bedi_pkg::*;

   localparam int S  = DIV_BITS_PER_STAGE;
   localparam int NS = (DW + S - 1) / S;
   localparam int PW = NS * S;

   logic [NS-1:0] valid_ff;
   logic [VW-1:0] rem_ff [NS];
   logic [VW-1:0] rem_in [NS];
   logic [PW-1:0] num_ff [NS];
   logic [PW-1:0] num_in [NS];
   logic [VW-1:0] den_ff [NS];
   logic [VW-1:0] den_in [NS];
   logic [SW-1:0] side_ff [NS];
   logic [SW-1:0] side_in [NS];

   // The numerator register holds the unused dividend bits on top and the
   // quotient bits found so far at the bottom.
   always_comb begin
      logic [VW-1:0] r;
      logic [PW-1:0] n;
      logic [VW-1:0] d;
      logic [VW:0]   t;
      for (int s = 0; s < NS; s++) begin
         if (s == 0) begin
            r = '0;
            n = PW'(in_dividend);
            d = in_divisor;
            side_in[s] = in_side;
         end else begin
            r = rem_ff[s-1];
            n = num_ff[s-1];
            d = den_ff[s-1];
            side_in[s] = side_ff[s-1];
         end
         for (int b = 0; b < S; b++) begin
            t = {r, n[PW-1]};
            n = {n[PW-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
               t = t - {1'b0, d};
               n[0] = 1'b1;
            end
            r = t[VW-1:0];
         end
         rem_in[s] = r;
         num_in[s] = n;
         den_in[s] = d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < NS; s++) begin
            rem_ff[s]  <= rem_in[s];
            num_ff[s]  <= num_in[s];
            den_ff[s]  <= den_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   assign out_valid    = valid_ff[NS-1];
   assign out_quotient = num_ff[NS-1][DW-1:0];
   assign out_side     = side_ff[NS-1];

endmodule
`default_nettype wire

/* rtl/core/battery_efficiency_degradation_index.sv */
// ----------------------------------------------------------------------------
// battery_efficiency_degradation_index
// Round-trip efficiency after a number of cycles and the risk level derived
// from the normalized efficiency loss.
// ----------------------------------------------------------------------------
// Usage:
//   A cycle count enters on req_valid/req_cycle_count and the matching word
//   leaves on rsp_valid with rsp_efficiency and rsp_risk_level, both Q1.16.
//   A word moves on a channel at a clock edge where valid is high and stall
//   is low. The csr_ channel writes the eight settings by index; csr_ready is
//   always high. The user must change settings only while no word is in
//   flight; the block itself does not enforce it. The pipeline has one
//   multiply stage, an 18-stage divider for the decay exponent, 6
//   range-reduction stages, 24 stages of the exp polynomial (three per term),
//   3 stages of scaling and clamping, a 13-stage divider for the loss index,
//   one stage of band selection, a 16-stage divider for band interpolation
//   and the output register. Throughput is one word per cycle while no stall
//   holds the pipeline. All stages move together: while the output register
//   holds a word that the receiver stalls, the whole pipeline holds and
//   req_stall is high. Reset empties the pipeline and loads the defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "battery_efficiency_degradation_index_assert.svh"
module battery_efficiency_degradation_index (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_cycle_count,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [16:0]      rsp_efficiency,
   output logic [16:0]      rsp_risk_level,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [16:0] csr_wdata
);
   import bedi_pkg::*;

   logic adv;

   // Settings
   logic [16:0] eta_start_ff;
   logic [16:0] eta_end_ff;
   logic [15:0] total_cycles_ff;
   logic [15:0] decay_beta_ff;
   logic [16:0] target_ratio_ff;
   logic [15:0] safe_ff;
   logic [15:0] gold_ff;
   logic [15:0] hard_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_start_ff    <= 17'd62259;
         eta_end_ff      <= 17'd52429;
         total_cycles_ff <= 16'd5000;
         decay_beta_ff   <= 16'd12288;
         target_ratio_ff <= 17'd58982;
         safe_ff         <= 16'd128;
         gold_ff         <= 16'd256;
         hard_ff         <= 16'd512;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ETA_START:    eta_start_ff    <= csr_wdata;
            CSR_ETA_END:      eta_end_ff      <= csr_wdata;
            CSR_TOTAL_CYCLES: total_cycles_ff <= csr_wdata[15:0];
            CSR_DECAY_BETA:   decay_beta_ff   <= csr_wdata[15:0];
            CSR_TARGET_RATIO: target_ratio_ff <= csr_wdata;
            CSR_SAFE_BOUND:   safe_ff         <= csr_wdata[15:0];
            CSR_GOLD_BOUND:   gold_ff         <= csr_wdata[15:0];
            CSR_HARD_BOUND:   hard_ff         <= csr_wdata[15:0];
         endcase
      end
   end

   // Output register frees the pipeline whenever it is empty or taken.
   logic        rsp_valid_ff;
   logic [16:0] rsp_efficiency_ff;
   logic [16:0] rsp_risk_level_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Stage 1: beta * cycle.
   logic        s1_valid_ff;
   logic        s1_zero_ff;
   logic [31:0] s1_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff <= 32'(decay_beta_ff) * 32'(req_cycle_count);
         s1_zero_ff <= (req_cycle_count == 16'd0);
      end
   end

   // Exponent x = beta * cycle * 16 / n in Q16.
   logic [15:0] n_div;
   logic        d1_valid;
   logic [35:0] d1_x;
   logic [0:0]  d1_zero;

   assign n_div = (total_cycles_ff == 16'd0) ? 16'd1 : total_cycles_ff;

   bedi_div #(.DW(36), .VW(16), .SW(1)) u_div_exp (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (s1_valid_ff),
      .in_dividend  ({s1_prod_ff, 4'b0000}),
      .in_divisor   (n_div),
      .in_side      (s1_zero_ff),
      .out_valid    (d1_valid),
      .out_quotient (d1_x),
      .out_side     (d1_zero)
   );

   // Range reduction x = i * ln2 + r, one quotient bit of i per stage.
   logic [5:0]  red_valid_ff;
   logic [5:0]  red_big_ff;
   logic [5:0]  red_zero_ff;
   logic [36:0] red_r_ff [6];
   logic [4:0]  red_i_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         red_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         red_valid_ff[0] <= d1_valid;
      end
   end

   // Beyond the limit the shift count reaches 32 and the exponential is zero.
   always_ff @(posedge clock) begin
      if (adv) begin
         red_big_ff[0]  <= (d1_x >= EXP_X_LIMIT);
         red_zero_ff[0] <= d1_zero[0];
         red_r_ff[0]    <= {d1_x[20:0], 16'h0000};
         red_i_ff[0]    <= 5'd0;
      end
   end

   for (genvar j = 1; j < 6; j++) begin : g_red
      localparam int SH = 5 - j;
      localparam logic [36:0] STEP = 37'(LN2_Q32) << SH;

      always_ff @(posedge clock) begin
         if (reset) begin
            red_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            red_valid_ff[j] <= red_valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            red_big_ff[j]  <= red_big_ff[j-1];
            red_zero_ff[j] <= red_zero_ff[j-1];
            if (red_r_ff[j-1] >= STEP) begin
               red_r_ff[j] <= red_r_ff[j-1] - STEP;
               red_i_ff[j] <= red_i_ff[j-1] | (5'd1 << SH);
            end else begin
               red_r_ff[j] <= red_r_ff[j-1];
               red_i_ff[j] <= red_i_ff[j-1];
            end
         end
      end
   end

   // Horner evaluation of exp(-r): p = 1 - floor((r * p >> 32) / k).
   logic [7:0]   hin_valid;
   logic [32:0]  hin_p [8];
   exp_side_type hin_side [8];

   logic [7:0]   ha_valid_ff;
   logic [63:0]  ha_prod_ff [8];
   exp_side_type ha_side_ff [8];
   logic [7:0]   hb_valid_ff;
   logic [31:0]  hb_m_ff [8];
   logic [31:0]  hb_q_ff [8];
   exp_side_type hb_side_ff [8];
   logic [7:0]   hc_valid_ff;
   logic [32:0]  hc_p_ff [8];
   exp_side_type hc_side_ff [8];

   for (genvar h = 0; h < 8; h++) begin : g_horner
      localparam int K = 8 - h;
      localparam logic [35:0] RECIP = 36'((64'd1 << 35) / K);
      localparam logic [31:0] KV = 32'(K);

      logic [67:0] mr;
      logic [31:0] q0;
      logic [31:0] rem;
      logic [31:0] t;

      if (h == 0) begin : g_first
         assign hin_valid[h]      = red_valid_ff[5];
         assign hin_p[h]          = ONE_Q32;
         assign hin_side[h].big   = red_big_ff[5];
         assign hin_side[h].zero  = red_zero_ff[5];
         assign hin_side[h].shift = red_i_ff[5];
         assign hin_side[h].r     = red_r_ff[5][31:0];
      end else begin : g_next
         assign hin_valid[h] = hc_valid_ff[h-1];
         assign hin_p[h]     = hc_p_ff[h-1];
         assign hin_side[h]  = hc_side_ff[h-1];
      end

      // The reciprocal estimate is low by at most one; the remainder fixes it.
      assign mr  = 68'(ha_prod_ff[h][63:32]) * 68'(RECIP);
      assign q0  = mr[66:35];
      assign rem = hb_m_ff[h] - hb_q_ff[h] * KV;
      assign t   = (rem >= KV) ? hb_q_ff[h] + 32'd1 : hb_q_ff[h];

      always_ff @(posedge clock) begin
         if (reset) begin
            ha_valid_ff[h] <= 1'b0;
            hb_valid_ff[h] <= 1'b0;
            hc_valid_ff[h] <= 1'b0;
         end else if (adv) begin
            ha_valid_ff[h] <= hin_valid[h];
            hb_valid_ff[h] <= ha_valid_ff[h];
            hc_valid_ff[h] <= hb_valid_ff[h];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ha_prod_ff[h] <= 64'(hin_side[h].r) * 64'(hin_p[h]);
            ha_side_ff[h] <= hin_side[h];
            hb_m_ff[h]    <= ha_prod_ff[h][63:32];
            hb_q_ff[h]    <= q0;
            hb_side_ff[h] <= ha_side_ff[h];
            hc_p_ff[h]    <= ONE_Q32 - {1'b0, t};
            hc_side_ff[h] <= hb_side_ff[h];
         end
      end
   end

   // Scale by 2^-i, then weight the efficiency span and clamp.
   logic        e_valid_ff;
   logic        e_zero_ff;
   logic [32:0] e_val_ff;
   logic        m_valid_ff;
   logic        m_zero_ff;
   logic [16:0] m_term_ff;
   logic        f_valid_ff;
   logic [16:0] f_eff_ff;
   logic [16:0] f_loss_ff;

   logic        dir_down;
   logic [16:0] span;
   logic [50:0] term_full;
   logic [17:0] eta_raw;
   logic [17:0] eta_lo;
   logic [16:0] eta_clamped;

   assign dir_down  = (eta_start_ff >= eta_end_ff);
   assign span      = dir_down ? eta_start_ff - eta_end_ff : eta_end_ff - eta_start_ff;
   assign term_full = 51'(span) * 51'(e_val_ff) + 51'h0_8000_0000;

   always_comb begin
      if (dir_down) begin
         eta_raw = 18'(eta_end_ff) + 18'(m_term_ff);
      end else begin
         eta_raw = 18'(eta_end_ff) - 18'(m_term_ff);
      end
      eta_lo = (eta_raw < 18'(eta_end_ff)) ? 18'(eta_end_ff) : eta_raw;
      if (m_zero_ff) begin
         eta_clamped = eta_start_ff;
      end else if (eta_lo > 18'(eta_start_ff)) begin
         eta_clamped = eta_start_ff;
      end else begin
         eta_clamped = eta_lo[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= hc_valid_ff[7];
         m_valid_ff <= e_valid_ff;
         f_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_zero_ff <= hc_side_ff[7].zero;
         e_val_ff  <= hc_side_ff[7].big ? 33'd0 : hc_p_ff[7] >> hc_side_ff[7].shift;
         m_zero_ff <= e_zero_ff;
         m_term_ff <= term_full[48:32];
         f_eff_ff  <= eta_clamped;
         f_loss_ff <= eta_start_ff - eta_clamped;
      end
   end

   // Loss index = (loss << 8) / (eta_start - target_ratio), or loss >> 8 when the target is not below the start.
   logic        pos_target;
   logic [16:0] loss_span;
   logic        d2_valid;
   logic [24:0] d2_q;
   logic [25:0] d2_side;

   assign pos_target = (eta_start_ff > target_ratio_ff);
   assign loss_span  = eta_start_ff - target_ratio_ff;

   bedi_div #(.DW(25), .VW(17), .SW(26)) u_div_idx (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (f_valid_ff),
      .in_dividend  ({f_loss_ff, 8'h00}),
      .in_divisor   (loss_span),
      .in_side      ({f_eff_ff, f_loss_ff[16:8]}),
      .out_valid    (d2_valid),
      .out_quotient (d2_q),
      .out_side     (d2_side)
   );

   logic        g_valid_ff;
   logic [15:0] g_idx_ff;
   logic [16:0] g_eff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (adv) begin
         g_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_eff_ff <= d2_side[25:9];
         if (!pos_target) begin
            g_idx_ff <= {7'd0, d2_side[8:0]};
         end else if (d2_q > 25'(IDX_MAX)) begin
            g_idx_ff <= IDX_MAX;
         end else begin
            g_idx_ff <= d2_q[15:0];
         end
      end
   end

   // Band selection; bands are tested in the order safe, hard, gold.
   logic [1:0]  band_mode;
   logic        band_half;
   logic [15:0] band_low;
   logic [15:0] band_high;
   logic [15:0] band_off;

   always_comb begin
      band_half = 1'b0;
      band_low  = safe_ff;
      band_high = gold_ff;
      priority if (g_idx_ff == IDX_MAX) begin
         band_mode = BAND_ONE;
      end else if (g_idx_ff <= safe_ff) begin
         band_mode = BAND_ZERO;
      end else if (g_idx_ff >= hard_ff) begin
         band_mode = BAND_ONE;
      end else if (g_idx_ff <= gold_ff) begin
         band_mode = BAND_LERP;
      end else begin
         band_mode = BAND_LERP;
         band_half = 1'b1;
         band_low  = gold_ff;
         band_high = hard_ff;
      end
      band_off = g_idx_ff - band_low;
   end

   logic        d3_valid;
   logic [30:0] d3_q;
   logic [19:0] d3_side;
   logic [16:0] risk;

   bedi_div #(.DW(31), .VW(16), .SW(20)) u_div_band (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (g_valid_ff),
      .in_dividend  ({band_off, 15'h0000}),
      .in_divisor   (band_high - band_low),
      .in_side      ({g_eff_ff, band_mode, band_half}),
      .out_valid    (d3_valid),
      .out_quotient (d3_q),
      .out_side     (d3_side)
   );

   always_comb begin
      unique case (d3_side[2:1])
         BAND_ZERO: risk = 17'd0;
         BAND_ONE:  risk = Q16_ONE;
         BAND_LERP: risk = (d3_side[0] ? Q16_HALF : 17'd0) + d3_q[16:0];
         default:   risk = 17'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_efficiency_ff <= d3_side[19:3];
         rsp_risk_level_ff <= risk;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_efficiency = rsp_efficiency_ff;
   assign rsp_risk_level = rsp_risk_level_ff;

   `BEDI_ASSERT_IMPLY(a_reduced_below_ln2, clock, reset, red_valid_ff[5] && !red_big_ff[5], red_r_ff[5] < 37'(LN2_Q32))
   `BEDI_ASSERT_IMPLY(a_exp_at_most_one, clock, reset, hc_valid_ff[7], hc_p_ff[7] <= ONE_Q32)
   `BEDI_ASSERT_IMPLY(a_risk_in_range, clock, reset, rsp_valid_ff, rsp_risk_level_ff <= Q16_ONE)
   `BEDI_ASSERT_NEXT(a_hold_first_stage, clock, reset, s1_valid_ff && !adv, s1_valid_ff)

endmodule
`default_nettype wire

/* test/bedi_checker.sv */
// ----------------------------------------------------------------------------
// Efficiency degradation index checker
// Watches the cycle count and result channels, computes the expected
// efficiency and risk level for every accepted word and compares them in order.
// ----------------------------------------------------------------------------
module bedi_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_cycle_count,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [16:0] rsp_efficiency,
   input  logic [16:0] rsp_risk_level,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          results_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import bedi_pkg::*;

   logic [16:0] eta_start_q, eta_end_q, target_q;
   logic [15:0] cycles_q, beta_q, safe_q, gold_q, hard_q;

   logic [16:0] eff_queue[$];
   logic [16:0] risk_queue[$];

   // exp(-x) for x in Q16, returned in Q32.
   function automatic logic [63:0] decay_q32(logic [63:0] x_q16);
      logic [63:0] xq, i, r, p, t;
      xq = x_q16 << 16;
      i = xq / 64'(LN2_Q32);
      r = xq - i * 64'(LN2_Q32);
      p = 64'(ONE_Q32);
      if (i >= 32) return 64'd0;
      for (int k = 8; k >= 1; k--) begin
         t = ((r * p) >> 32) / 64'(k);
         p = (t >= 64'(ONE_Q32)) ? 64'd0 : 64'(ONE_Q32) - t;
      end
      return p >> i;
   endfunction

   function automatic logic [31:0] efficiency_after(logic [15:0] cyc);
      logic [63:0] n, x, e, term;
      logic [31:0] eta;
      n = (cycles_q == 0) ? 64'd1 : 64'(cycles_q);
      if (cyc == 0) return 32'(eta_start_q);
      x = (64'(beta_q) * 64'(cyc) * 64'd16) / n;
      e = decay_q32(x);
      if (eta_start_q >= eta_end_q) begin
         term = (64'(eta_start_q - eta_end_q) * e + 64'h8000_0000) >> 32;
         eta = 32'(eta_end_q) + 32'(term);
      end else begin
         term = (64'(eta_end_q - eta_start_q) * e + 64'h8000_0000) >> 32;
         eta = 32'(eta_end_q) - 32'(term);
      end
      if (eta < 32'(eta_end_q)) eta = 32'(eta_end_q);
      if (eta > 32'(eta_start_q)) eta = 32'(eta_start_q);
      return eta;
   endfunction

   function automatic logic [31:0] risk_of_index(logic [31:0] idx);
      if (idx >= 32'(IDX_MAX)) return 32'(Q16_ONE);
      if (idx <= 32'(safe_q)) return 32'd0;
      if (idx >= 32'(hard_q)) return 32'(Q16_ONE);
      if (idx <= 32'(gold_q))
         return 32'((64'(idx - safe_q) * 64'(Q16_HALF)) / 64'(gold_q - safe_q));
      return 32'(Q16_HALF) +
             32'((64'(idx - gold_q) * 64'(Q16_HALF)) / 64'(hard_q - gold_q));
   endfunction

   always @(posedge clock) begin
      logic [31:0] eff, loss, idx, risk;
      logic [63:0] q;
      if (reset) begin
         eta_start_q <= 17'd62259;
         eta_end_q   <= 17'd52429;
         cycles_q    <= 16'd5000;
         beta_q      <= 16'd12288;
         target_q    <= 17'd58982;
         safe_q      <= 16'd128;
         gold_q      <= 16'd256;
         hard_q      <= 16'd512;
         fail_count  <= 0;
         results_seen <= 0;
         eff_queue.delete();
         risk_queue.delete();
      end else begin
         if (req_valid && !req_stall) begin
            eff = efficiency_after(req_cycle_count);
            loss = 32'(eta_start_q) - eff;
            if (eta_start_q > target_q) begin
               q = (64'(loss) << 8) / 64'(eta_start_q - target_q);
               idx = (q > 64'(IDX_MAX)) ? 32'(IDX_MAX) : 32'(q);
            end else begin
               idx = loss >> 8;
            end
            risk = risk_of_index(idx);
            eff_queue.push_back(eff[16:0]);
            risk_queue.push_back(risk[16:0]);
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (eff_queue.size() == 0) begin
               $display("%0t: result word with nothing expected: eff %0d risk %0d",
                        $time, rsp_efficiency, rsp_risk_level);
               fail_count <= fail_count + 1;
            end else begin
               if (eff_queue[0] !== rsp_efficiency || risk_queue[0] !== rsp_risk_level) begin
                  $display("%0t: mismatch: expected eff %0d risk %0d, got eff %0d risk %0d",
                           $time, eff_queue[0], risk_queue[0],
                           rsp_efficiency, rsp_risk_level);
                  fail_count <= fail_count + 1;
               end
               void'(eff_queue.pop_front());
               void'(risk_queue.pop_front());
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ETA_START:    eta_start_q <= csr_wdata;
               CSR_ETA_END:      eta_end_q   <= csr_wdata;
               CSR_TOTAL_CYCLES: cycles_q    <= csr_wdata[15:0];
               CSR_DECAY_BETA:   beta_q      <= csr_wdata[15:0];
               CSR_TARGET_RATIO: target_q    <= csr_wdata;
               CSR_SAFE_BOUND:   safe_q      <= csr_wdata[15:0];
               CSR_GOLD_BOUND:   gold_q      <= csr_wdata[15:0];
               default:          hard_q      <= csr_wdata[15:0];
            endcase
         end
      end
   end

   assign pending = eff_queue.size();
endmodule

/* test/tb_battery_efficiency_degradation_index.sv */
// ----------------------------------------------------------------------------
// Efficiency degradation index testbench
// Drives cycle counts under several register settings with random gaps and
// receiver stalls; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_battery_efficiency_degradation_index;
   timeunit 1ns;
   timeprecision 1ps;
   import bedi_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_cycle_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [16:0] rsp_efficiency, rsp_risk_level;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [16:0] csr_wdata = '0;
   int          fail_count, pending, results_seen;
   int          words_sent = 0;
   bit          long_hold = 1'b0;

   battery_efficiency_degradation_index dut (.*);

   bedi_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // csr_valid drops after each write, which keeps back-to-back writes apart.
   task automatic write_reg(logic [2:0] idx, logic [16:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Valid stays high after an accepted word; a gap or a drain lowers it.
   task automatic send_count(logic [15:0] cyc, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cycle_count <= cyc;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // Settings are only changed once the pipeline has fully drained.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [15:0] random_count();
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(0, 15));
         1: return 16'($urandom_range(0, 65535));
         2: return 16'hFFFF - 16'($urandom_range(0, 15));
         default: return 16'($urandom_range(0, 20000));
      endcase
   endfunction

   task automatic random_settings();
      logic [15:0] b0, b1, b2;
      write_reg(CSR_ETA_START, 17'($urandom_range(0, 65536)));
      write_reg(CSR_ETA_END, 17'($urandom_range(0, 65536)));
      write_reg(CSR_TOTAL_CYCLES, 17'($urandom_range(0, 65535)));
      write_reg(CSR_DECAY_BETA, 17'($urandom_range(0, 65535)));
      write_reg(CSR_TARGET_RATIO, 17'($urandom_range(0, 65536)));
      b0 = 16'($urandom_range(0, 2000));
      b1 = b0 + 16'($urandom_range(1, 2000));
      b2 = b1 + 16'($urandom_range(1, 2000));
      if ($urandom_range(0, 5) == 0) begin
         b0 = 16'($urandom); b1 = 16'($urandom); b2 = 16'($urandom);
      end
      write_reg(CSR_SAFE_BOUND, 17'(b0));
      write_reg(CSR_GOLD_BOUND, 17'(b1));
      write_reg(CSR_HARD_BOUND, 17'(b2));
   endtask

   // Receiver: random stalls per word, no stalls in some stretches of words, one long hold.
   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else if (rsp_valid && !rsp_stall) begin
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (words_sent % 400 < 60) wait_cycles = 0;
            if (wait_cycles != 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_cycles) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [15:0] edge_counts[8] = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'h8000,
                                     16'h00FF, 16'h5555, 16'hAAAA};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: default settings, field extremes.
      foreach (edge_counts[i]) send_count(edge_counts[i], 0);
      drain();
      // Zero total cycles, floor above initial, target above start.
      write_reg(CSR_TOTAL_CYCLES, 17'd0);
      write_reg(CSR_ETA_START, 17'd40000);
      write_reg(CSR_ETA_END, 17'd60000);
      write_reg(CSR_TARGET_RATIO, 17'd65536);
      foreach (edge_counts[i]) send_count(edge_counts[i], 0);
      drain();
      // Extremes: full start, zero floor, max beta, misordered bands.
      write_reg(CSR_ETA_START, 17'd65536);
      write_reg(CSR_ETA_END, 17'd0);
      write_reg(CSR_TOTAL_CYCLES, 17'hFFFF);
      write_reg(CSR_DECAY_BETA, 17'hFFFF);
      write_reg(CSR_TARGET_RATIO, 17'd65535);
      write_reg(CSR_SAFE_BOUND, 17'd1000);
      write_reg(CSR_GOLD_BOUND, 17'd50);
      write_reg(CSR_HARD_BOUND, 17'hFFFF);
      foreach (edge_counts[i]) send_count(edge_counts[i], 0);
      drain();

      // Random phases with a long receiver hold in the second one.
      for (int phase = 0; phase < 8; phase++) begin
         if (phase > 0) random_settings();
         if (phase == 1) long_hold = 1'b1;
         for (int n = 0; n < 150; n++)
            send_count(random_count(),
                       (n % 50 < 10 || long_hold) ? 0 : $urandom_range(0, 18));
         drain();
      end

      $display("Sent %0d cycle counts over ten register settings; %0d results checked.",
               words_sent, results_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/bedi_pkg.sv
rtl/core/bedi_div.sv
rtl/core/battery_efficiency_degradation_index.sv
test/bedi_checker.sv
test/tb_battery_efficiency_degradation_index.sv
